/* hdl/luop_pkg.sv */
// Shared types, field layout and popcount helper for the leave-one-out union popcount block.
package luop_pkg;

    // Input beat layout: seed_slot, seed_node, tabu_expiry, mask_word (last_column on tlast)
    localparam int SLOT_W      = 5;
    localparam int NODE_W      = 20;
    localparam int EXPIRY_W    = 25;
    localparam int WORD_W      = 64;
    localparam int S_TDATA_W   = 120;
    localparam int SLOT_LSB    = 0;
    localparam int NODE_LSB    = SLOT_LSB + SLOT_W;
    localparam int EXPIRY_LSB  = NODE_LSB + NODE_W;
    localparam int WORD_LSB    = EXPIRY_LSB + EXPIRY_W;

    // Result beat layout: removed_node, without_count, full_count (has_removal on tuser)
    localparam int COUNT_W     = 17;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAD_W     = M_TDATA_W - NODE_W - 2 * COUNT_W;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int SEED_CNT_W  = 6;
    localparam int ITER_W      = 24;
    localparam int POP_W       = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SEEDS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_ITER = 1'd1;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic    item_load;
        logic    fwd_step;
        logic    bwd_step;
        cnt_op_t cnt_op;
        logic    out_load_seed;
        logic    out_load_none;
        logic    clear_counts;
    } luop_cmd_t;

    typedef struct packed {
        logic col_end;
        logic last_col;
        logic cnt_at_top;
        logic cnt_at_zero;
        logic cur_free;
        logic last_free;
        logic any_free;
        logic out_free;
    } luop_status_t;

    // Adder tree, six levels
    function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

/* hdl/luop_ctrl.sv */
// Sequencing state machine: column load, prefix and suffix passes, result emission.
module luop_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  luop_pkg::luop_status_t st,
    output luop_pkg::luop_cmd_t   cmd
);
    import luop_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DRAIN,
        ST_EMIT,
        ST_NONE
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cnt_op = CNT_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    if (st.col_end) begin
                        cmd.cnt_op = CNT_ZERO;
                        state_next = ST_FWD;
                    end
                end
            end
            ST_FWD: begin
                cmd.fwd_step = 1'b1;
                // counter already sits on the top slot, where the suffix pass starts
                if (st.cnt_at_top) begin
                    state_next = ST_BWD;
                end else begin
                    cmd.cnt_op = CNT_INC;
                end
            end
            ST_BWD: begin
                cmd.bwd_step = 1'b1;
                if (st.cnt_at_zero) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            ST_DRAIN: begin
                // let the final accumulate land before anything reads the counts
                if (!st.last_col) begin
                    state_next = ST_IDLE;
                end else if (st.any_free) begin
                    cmd.cnt_op = CNT_ZERO;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_NONE;
                end
            end
            ST_EMIT: begin
                if (!st.cur_free) begin
                    cmd.cnt_op = CNT_INC;
                end else if (st.out_free) begin
                    cmd.out_load_seed = 1'b1;
                    if (st.last_free) begin
                        cmd.clear_counts = 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        cmd.cnt_op = CNT_INC;
                    end
                end
            end
            ST_NONE: begin
                if (st.out_free) begin
                    cmd.out_load_none = 1'b1;
                    cmd.clear_counts  = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/luop_dp.sv */
// Datapath: slot stores, prefix and suffix OR, popcount, saturating counts, output register.
module luop_dp #(
    parameter int MAX_SEEDS = 32,
    parameter int MAX_WORDS = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [luop_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [luop_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_wr_en,
    input  logic [luop_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [luop_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  luop_pkg::luop_cmd_t                   cmd,
    output luop_pkg::luop_status_t                st
);
    import luop_pkg::*;

    localparam int SLOT_CAP = (MAX_SEEDS < 32) ? MAX_SEEDS : 32;
    localparam int IDX_W    = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
    localparam logic [SEED_CNT_W-1:0] SLOT_CAP_N = SEED_CNT_W'(SLOT_CAP);
    localparam logic [COUNT_W:0]      COUNT_CAP  = (COUNT_W + 1)'(MAX_WORDS * 64);

    // Configuration
    logic [SEED_CNT_W-1:0] seeds_reg;
    logic [ITER_W-1:0]     cur_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeds_reg    <= SEED_CNT_W'(1);
            cur_iter_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SEEDS:    seeds_reg    <= cfg_wdata[SEED_CNT_W-1:0];
                REG_CUR_ITER: cur_iter_reg <= cfg_wdata[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [SEED_CNT_W-1:0] n_eff;
    logic [SEED_CNT_W-1:0] top;

    always_comb begin
        if (seeds_reg == '0) begin
            n_eff = SEED_CNT_W'(1);
        end else if (seeds_reg > SLOT_CAP_N) begin
            n_eff = SLOT_CAP_N;
        end else begin
            n_eff = seeds_reg;
        end
    end
    assign top = n_eff - SEED_CNT_W'(1);

    // Input beat fields
    logic [SLOT_W-1:0]          in_slot;
    logic [NODE_W-1:0]          in_node;
    logic signed [EXPIRY_W-1:0] in_expiry;
    logic [WORD_W-1:0]          in_word;
    logic                       slot_ok;
    logic                       in_free;
    logic [IDX_W-1:0]           wr_idx;

    assign in_slot   = s_tdata[SLOT_LSB +: SLOT_W];
    assign in_node   = s_tdata[NODE_LSB +: NODE_W];
    assign in_expiry = s_tdata[EXPIRY_LSB +: EXPIRY_W];
    assign in_word   = s_tdata[WORD_LSB +: WORD_W];
    assign slot_ok   = SEED_CNT_W'(in_slot) < n_eff;
    assign wr_idx    = in_slot[IDX_W-1:0];
    // negative expiry is always below the iteration
    assign in_free   = in_expiry[EXPIRY_W-1] || (in_expiry[ITER_W-1:0] < cur_iter_reg);

    // Slot stores
    logic [WORD_W-1:0]   cw_reg   [SLOT_CAP];
    logic [WORD_W-1:0]   pf_reg   [SLOT_CAP];
    logic [NODE_W-1:0]   node_reg [SLOT_CAP];
    logic [SLOT_CAP-1:0] free_reg;
    logic [COUNT_W-1:0]  wo_accum_reg [SLOT_CAP];
    logic [COUNT_W-1:0]  full_accum_reg;

    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] run_reg, suf_reg;
    logic              last_col_reg;
    logic              cnt_at_top;

    assign cnt_at_top = (SEED_CNT_W'(cnt_reg) == top);

    always_comb begin
        case (cmd.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_ZERO: cnt_next = '0;
            CNT_INC:  cnt_next = cnt_reg + IDX_W'(1);
            CNT_DEC:  cnt_next = cnt_reg - IDX_W'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load && slot_ok) begin
            cw_reg[wr_idx]   <= in_word;
            node_reg[wr_idx] <= in_node;
        end
        if (cmd.fwd_step) begin
            pf_reg[cnt_reg] <= run_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (cmd.item_load) begin
            run_reg <= '0;
        end else if (cmd.fwd_step) begin
            run_reg <= run_reg | cw_reg[cnt_reg];
        end
        if (cmd.fwd_step && cnt_at_top) begin
            suf_reg <= '0;
        end else if (cmd.bwd_step) begin
            suf_reg <= suf_reg | cw_reg[cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg     <= '0;
            last_col_reg <= 1'b0;
        end else if (cmd.item_load && slot_ok) begin
            free_reg[wr_idx] <= in_free;
            // only the mark on the column-ending beat counts
            if (SEED_CNT_W'(in_slot) == top) begin
                last_col_reg <= s_tlast;
            end
        end
    end

    // Popcount stage, then saturating accumulate
    logic               pop_vld_reg, pop_full_reg;
    logic [IDX_W-1:0]   pop_idx_reg;
    logic [POP_W-1:0]   pop_val_reg;
    logic [WORD_W-1:0]  pop_src;

    assign pop_src = cmd.bwd_step ? (pf_reg[cnt_reg] | suf_reg)
                                  : (run_reg | cw_reg[cnt_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_vld_reg <= 1'b0;
        end else begin
            pop_vld_reg <= cmd.bwd_step || (cmd.fwd_step && cnt_at_top);
        end
        pop_full_reg <= cmd.fwd_step;
        pop_idx_reg  <= cnt_reg;
        pop_val_reg  <= pop64(pop_src);
    end

    logic [COUNT_W:0]   acc_sum;
    logic [COUNT_W-1:0] acc_sat;

    assign acc_sum = (pop_full_reg ? {1'b0, full_accum_reg}
                                   : {1'b0, wo_accum_reg[pop_idx_reg]})
                   + (COUNT_W + 1)'(pop_val_reg);
    assign acc_sat = (acc_sum > COUNT_CAP) ? COUNT_CAP[COUNT_W-1:0] : acc_sum[COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_counts) begin
            full_accum_reg <= '0;
            for (int i = 0; i < SLOT_CAP; i++) begin
                wo_accum_reg[i] <= '0;
            end
        end else if (pop_vld_reg) begin
            if (pop_full_reg) begin
                full_accum_reg <= acc_sat;
            end else begin
                wo_accum_reg[pop_idx_reg] <= acc_sat;
            end
        end
    end

    // Free seeds within the active slots, and those after the counter
    logic [SLOT_CAP-1:0] free_act, free_above;

    always_comb begin
        for (int j = 0; j < SLOT_CAP; j++) begin
            free_act[j]   = free_reg[j] && (SEED_CNT_W'(j) < n_eff);
            free_above[j] = free_act[j] && (IDX_W'(j) > cnt_reg);
        end
    end

    // Output register
    logic               m_tvalid_reg;
    logic               has_out_reg, last_out_reg;
    logic [NODE_W-1:0]  node_out_reg;
    logic [COUNT_W-1:0] wo_out_reg, full_out_reg;
    logic               out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load_seed || cmd.out_load_none) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load_seed) begin
            has_out_reg  <= 1'b1;
            node_out_reg <= node_reg[cnt_reg];
            wo_out_reg   <= wo_accum_reg[cnt_reg];
            full_out_reg <= full_accum_reg;
            last_out_reg <= ~|free_above;
        end else if (cmd.out_load_none) begin
            has_out_reg  <= 1'b0;
            node_out_reg <= '0;
            wo_out_reg   <= '0;
            full_out_reg <= full_accum_reg;
            last_out_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, full_out_reg, wo_out_reg, node_out_reg};
    assign m_tuser  = has_out_reg;
    assign m_tlast  = last_out_reg;

    assign st.col_end     = slot_ok && (SEED_CNT_W'(in_slot) == top);
    assign st.last_col    = last_col_reg;
    assign st.cnt_at_top  = cnt_at_top;
    assign st.cnt_at_zero = (cnt_reg == '0);
    assign st.cur_free    = free_reg[cnt_reg];
    assign st.last_free   = ~|free_above;
    assign st.any_free    = |free_act;
    assign st.out_free    = out_free;

endmodule

/* hdl/leave_one_out_union_popcount.sv */
// Top level: leave-one-out union popcount over the seed set of one sampled graph.
//
// Input beats on s_* carry one seed slot's 64-bit mask word of the current column;
// s_tlast marks words of the final column. A column ends with the beat for the top
// active slot (seed count - 1); beats with a slot at or above the seed count are dropped.
// A beat that does not end a column is only stored. A column-ending beat is accepted,
// then a prefix pass over the active slots builds the prefix ORs, a suffix pass takes
// the popcounts, and a drain step lets the final counts settle.
// After the final column, results leave on m_* in slot order, one per free seed
// (m_tuser = 1), at most one per cycle; m_tlast marks the last result of the sample.
// m_tvalid first rises once the counts have settled and the scan over the slots reaches
// the first free one. With no free seed a single beat with m_tuser = 0 carries the full
// count.
// No input is taken while a column is processed or until the last result of the sample
// has entered the output register. A stalled receiver holds the output register;
// emission waits, nothing is lost. Reset clears the counts, the free flags and the
// output valid; the seed count returns to 1 and current_iteration to 0. Write the
// configuration only while the block is idle.
module leave_one_out_union_popcount #(
    parameter int MAX_SEEDS = 32,
    parameter int MAX_WORDS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: seed_slot[4:0], seed_node[24:5], tabu_expiry[49:25], mask_word[113:50]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [luop_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    // m_tdata: removed_node[19:0], without_count[36:20], full_count[53:37]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [luop_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: has_removal[0]
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [luop_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [luop_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import luop_pkg::*;

    luop_cmd_t    cmd;
    luop_status_t st;

    luop_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    luop_dp #(
        .MAX_SEEDS (MAX_SEEDS),
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
